/* rtl/aste_pkg.sv */
// shared types and constants for the air shelf and tilt equalizer
package aste_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_AIR_GAIN   = 2'd0;
  localparam logic [1:0] REG_AIR_COEFF  = 2'd1;
  localparam logic [1:0] REG_TILT_GAIN  = 2'd2;
  localparam logic [1:0] REG_TILT_COEFF = 2'd3;

  // tilt stage runs only when |gain| exceeds this
  localparam int TILT_DEAD = 3;

  typedef struct packed {
    logic signed [23:0] sample_in;
    logic        [2:0]  channel;
    logic               block_end;
  } req_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic        [2:0]  channel_out;
    logic               block_end_out;
    logic               clipped;
  } rsp_t;

  typedef struct packed {
    logic        [15:0] air_gain;
    logic        [15:0] air_coeff;
    logic signed [15:0] tilt_gain;
    logic        [15:0] tilt_coeff;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AIR_MC,
    ST_AIR_UPD,
    ST_AIR_MG,
    ST_AIR_OUT,
    ST_TILT_PREP,
    ST_TILT_MC,
    ST_TILT_UPD,
    ST_TILT_MG,
    ST_TILT_OUT,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_AC,
    OP_AIR_UPD,
    OP_MUL_AG,
    OP_AIR_OUT,
    OP_TILT_PREP,
    OP_MUL_TC,
    OP_TILT_UPD,
    OP_MUL_TG,
    OP_TILT_OUT,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;     // incoming channel has filter state
    logic air_on;
    logic tilt_on;
    logic out_free;  // output register can take a word
  } status_t;

endpackage

/* rtl/aste_cfg.sv */
// configuration register file for the equalizer
module aste_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output aste_pkg::cfg_regs_t regs
);

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aste_pkg::REG_AIR_GAIN:   regs.air_gain   <= cfg_data;
        aste_pkg::REG_AIR_COEFF:  regs.air_coeff  <= cfg_data;
        aste_pkg::REG_TILT_GAIN:  regs.tilt_gain  <= cfg_data;
        aste_pkg::REG_TILT_COEFF: regs.tilt_coeff <= cfg_data;
      endcase
    end
  end

endmodule

/* rtl/aste_ctrl.sv */
// sequencing state machine for the equalizer
module aste_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  aste_pkg::status_t status,
  output aste_pkg::cmd_t    cmd
);

  aste_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aste_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = aste_pkg::OP_NONE;
    req_stall  = 1'b1;
    unique case (state)
      aste_pkg::ST_IDLE: begin
        req_stall = rst;
        if (req_valid && !rst) begin
          cmd.op = aste_pkg::OP_LOAD;
          priority if (!status.ch_ok) begin
            state_next = aste_pkg::ST_FINISH;
          end else if (status.air_on) begin
            state_next = aste_pkg::ST_AIR_MC;
          end else begin
            state_next = aste_pkg::ST_TILT_PREP;
          end
        end
      end
      aste_pkg::ST_AIR_MC: begin
        cmd.op     = aste_pkg::OP_MUL_AC;
        state_next = aste_pkg::ST_AIR_UPD;
      end
      aste_pkg::ST_AIR_UPD: begin
        cmd.op     = aste_pkg::OP_AIR_UPD;
        state_next = aste_pkg::ST_AIR_MG;
      end
      aste_pkg::ST_AIR_MG: begin
        cmd.op     = aste_pkg::OP_MUL_AG;
        state_next = aste_pkg::ST_AIR_OUT;
      end
      aste_pkg::ST_AIR_OUT: begin
        cmd.op     = aste_pkg::OP_AIR_OUT;
        state_next = aste_pkg::ST_TILT_PREP;
      end
      aste_pkg::ST_TILT_PREP: begin
        cmd.op     = aste_pkg::OP_TILT_PREP;
        state_next = status.tilt_on ? aste_pkg::ST_TILT_MC : aste_pkg::ST_FINISH;
      end
      aste_pkg::ST_TILT_MC: begin
        cmd.op     = aste_pkg::OP_MUL_TC;
        state_next = aste_pkg::ST_TILT_UPD;
      end
      aste_pkg::ST_TILT_UPD: begin
        cmd.op     = aste_pkg::OP_TILT_UPD;
        state_next = aste_pkg::ST_TILT_MG;
      end
      aste_pkg::ST_TILT_MG: begin
        cmd.op     = aste_pkg::OP_MUL_TG;
        state_next = aste_pkg::ST_TILT_OUT;
      end
      aste_pkg::ST_TILT_OUT: begin
        cmd.op     = aste_pkg::OP_TILT_OUT;
        state_next = aste_pkg::ST_FINISH;
      end
      aste_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.op     = aste_pkg::OP_FINISH;
          state_next = aste_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aste_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/aste_dp.sv */
// datapath: shared multiplier, per-channel lowpass state, output register
module aste_dp #(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  aste_pkg::req_t      req_data,
  input  aste_pkg::cfg_regs_t regs,
  input  aste_pkg::cmd_t      cmd,
  output aste_pkg::status_t   status,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output aste_pkg::rsp_t      rsp_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = -32'sh7FFF_FFFF - 32'sd1;
  localparam logic signed [28:0] S_MAX = 29'sd8388607;
  localparam logic signed [28:0] S_MIN = -29'sd8388608;

  logic signed [31:0] air_lp  [CHANNELS];
  logic signed [31:0] tilt_lp [CHANNELS];

  logic signed [31:0] xs_r;
  logic signed [31:0] y_r;
  logic signed [31:0] lp_r;
  logic signed [33:0] diff_r;
  logic signed [50:0] prod_r;
  logic signed [35:0] z_r;
  logic [IDX_W-1:0]   idx_r;
  logic [2:0]         ch_r;
  logic               be_r;
  logic               clip_r;
  logic               out_valid;
  aste_pkg::rsp_t     out_r;

  logic [IDX_W-1:0]   idx_in;
  logic signed [31:0] xs_in;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod_full;
  logic signed [50:0] rnd16, rnd14, rnd15;
  logic signed [31:0] lp_new;
  logic signed [37:0] ysum;
  logic signed [31:0] ysat;
  logic               yclip;
  logic signed [36:0] zsum;
  logic signed [36:0] zrnd;
  logic signed [28:0] zint;
  logic signed [23:0] zsat;
  logic               zclip;

  assign idx_in = IDX_W'(req_data.channel);
  assign xs_in  = {req_data.sample_in, 8'd0};

  assign status.ch_ok    = 32'(req_data.channel) < CHANNELS;
  assign status.air_on   = regs.air_gain != 16'd0;
  assign status.tilt_on  = (regs.tilt_gain > 16'(aste_pkg::TILT_DEAD))
                        || (regs.tilt_gain < -16'(aste_pkg::TILT_DEAD));
  assign status.out_free = !out_valid || !rsp_stall;

  // shared multiplier, coefficient or gain times registered difference
  always_comb begin
    unique case (cmd.op)
      aste_pkg::OP_MUL_AC: mul_b = {1'b0, regs.air_coeff};
      aste_pkg::OP_MUL_AG: mul_b = {1'b0, regs.air_gain};
      aste_pkg::OP_MUL_TC: mul_b = {1'b0, regs.tilt_coeff};
      aste_pkg::OP_MUL_TG: mul_b = {regs.tilt_gain[15], regs.tilt_gain};
      default:             mul_b = '0;
    endcase
  end

  assign prod_full = diff_r * mul_b;

  // rounded shifts of the product, half up
  assign rnd16  = prod_r + 51'sd32768;
  assign rnd14  = prod_r + 51'sd8192;
  assign rnd15  = prod_r + 51'sd16384;
  assign lp_new = lp_r + rnd16[47:16];

  // air output, saturated to the internal word
  assign ysum = 38'(xs_r) + 38'($signed(rnd14[50:14]));
  always_comb begin
    yclip = 1'b0;
    ysat  = ysum[31:0];
    if (ysum > 38'(Q_MAX)) begin
      ysat  = Q_MAX;
      yclip = 1'b1;
    end else if (ysum < 38'(Q_MIN)) begin
      ysat  = Q_MIN;
      yclip = 1'b1;
    end
  end

  assign zsum = 37'(y_r) + 37'($signed(rnd15[50:15]));

  // final rounding to integer samples and saturation
  assign zrnd = 37'(z_r) + 37'sd128;
  assign zint = zrnd[36:8];
  always_comb begin
    zclip = 1'b0;
    zsat  = zint[23:0];
    if (zint > S_MAX) begin
      zsat  = S_MAX[23:0];
      zclip = 1'b1;
    end else if (zint < S_MIN) begin
      zsat  = S_MIN[23:0];
      zclip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      aste_pkg::OP_LOAD: begin
        xs_r   <= xs_in;
        y_r    <= xs_in;
        z_r    <= 36'(xs_in);
        lp_r   <= air_lp[idx_in];
        diff_r <= 34'(xs_in) - 34'(air_lp[idx_in]);
        idx_r  <= idx_in;
        ch_r   <= req_data.channel;
        be_r   <= req_data.block_end;
      end
      aste_pkg::OP_MUL_AC, aste_pkg::OP_MUL_AG,
      aste_pkg::OP_MUL_TC, aste_pkg::OP_MUL_TG: begin
        prod_r <= prod_full;
      end
      aste_pkg::OP_AIR_UPD: begin
        lp_r   <= lp_new;
        diff_r <= 34'(xs_r) - 34'(lp_new);
      end
      aste_pkg::OP_AIR_OUT: begin
        y_r <= ysat;
      end
      aste_pkg::OP_TILT_PREP: begin
        lp_r   <= tilt_lp[idx_r];
        diff_r <= 34'(y_r) - 34'(tilt_lp[idx_r]);
        z_r    <= 36'(y_r);
      end
      aste_pkg::OP_TILT_UPD: begin
        lp_r   <= lp_new;
        diff_r <= 34'(y_r) - {lp_new[31], lp_new, 1'b0};
      end
      aste_pkg::OP_TILT_OUT: begin
        z_r <= zsum[35:0];
      end
      default: begin
      end
    endcase
  end

  // clip flag and per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        air_lp[i]  <= '0;
        tilt_lp[i] <= '0;
      end
    end else begin
      if (cmd.op == aste_pkg::OP_LOAD) begin
        clip_r <= 1'b0;
      end else if (cmd.op == aste_pkg::OP_AIR_OUT && yclip) begin
        clip_r <= 1'b1;
      end
      if (cmd.op == aste_pkg::OP_AIR_UPD) begin
        air_lp[idx_r] <= lp_new;
      end
      if (cmd.op == aste_pkg::OP_TILT_UPD) begin
        tilt_lp[idx_r] <= lp_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == aste_pkg::OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (!rsp_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == aste_pkg::OP_FINISH) begin
      out_r.sample_out    <= zsat;
      out_r.channel_out   <= ch_r;
      out_r.block_end_out <= be_r;
      out_r.clipped       <= clip_r | zclip;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp_data  = out_r;

endmodule

/* rtl/air_shelf_and_tilt_eq_core.sv */
// top level of the air shelf and tilt equalizer
//
// usage
// - req channel: req_valid, req_stall, req_data (sample_in, channel, block_end).
//   a word is taken at a clock edge with req_valid high and req_stall low
// - rsp channel: rsp_valid, rsp_stall, rsp_data (sample_out, channel_out,
//   block_end_out, clipped), one result word for every request word
// - cfg channel: cfg_valid, cfg_ready, cfg_index, cfg_data; cfg_ready is
//   high outside reset, write only while no word is in flight
// - timing: one request word at a time; a shared 34x17 multiplier does the
//   four products, each a multiply step followed by an accumulate step.
//   a bypassed stage skips its steps, and a channel without state skips
//   all of them; the next word is taken once the block is back in idle,
//   after the result is loaded into the output register
// - a stalled rsp word holds in the output register; the block finishes the
//   next word and then waits in its last step until the register frees up
// - reset (rst, synchronous) clears config registers, all lowpass state
//   and the output valid; no word or write is taken while it is high
module air_shelf_and_tilt_eq_core #(
  parameter int CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst,
  // request words
  input  logic           req_valid,
  output logic           req_stall,
  input  aste_pkg::req_t req_data,
  // result words
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output aste_pkg::rsp_t rsp_data,
  // register writes
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  aste_pkg::cfg_regs_t regs;
  aste_pkg::cmd_t      cmd;
  aste_pkg::status_t   status;

  // gain and coefficient registers
  aste_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // step sequencer, skips bypassed stages
  aste_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, filter state and result register
  aste_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .regs      (regs),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
